/* src/srpc_pkg.sv */
package srpc_pkg;

    // Field widths fixed by the item format
    localparam int BAND_W    = 16;
    localparam int RATIO_W   = 16;
    localparam int SD_W      = 24;
    localparam int DIVISOR_W = 17;

    // Defaults for the top-level parameters
    localparam int TABLE_ENTRIES_DEF = 256;
    localparam int CLASSES_DEF       = 64;

    // Item action codes
    localparam logic [1:0] ACT_RATIO = 2'd0;
    localparam logic [1:0] ACT_CLASS = 2'd1;
    localparam logic [1:0] ACT_BAND  = 2'd2;

    // Distance norm codes (code 3 behaves as maximum)
    localparam logic [1:0] NORM_MAX  = 2'd0;
    localparam logic [1:0] NORM_MEAN = 2'd1;
    localparam logic [1:0] NORM_RMS  = 2'd2;

    // Configuration register indexes
    localparam logic [2:0] CFG_PAN    = 3'd0;
    localparam logic [2:0] CFG_SWAP   = 3'd1;
    localparam logic [2:0] CFG_SHADOW = 3'd2;
    localparam logic [2:0] CFG_NORM   = 3'd3;
    localparam logic [2:0] CFG_RONLY  = 3'd4;
    localparam logic [2:0] CFG_MINSIG = 3'd5;
    localparam logic [2:0] CFG_COUNT  = 3'd6;

    // Last band of a pixel
    localparam logic [3:0] LAST_BAND = 4'd15;

    typedef struct packed {
        logic [3:0]  band_a;
        logic [3:0]  band_b;
        logic [6:0]  cls;
        logic [15:0] mean;
        logic [15:0] sigma;
    } t_ratio_entry;

    typedef struct packed {
        logic [15:0] change_thr;
        logic [15:0] dist_thr;
        logic [7:0]  priority_lvl;
    } t_class_entry;

endpackage

/* src/srpc_div.sv */
module srpc_div #(
    parameter int DW = 57
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [DW-1:0]              i_dividend,
    input  logic [srpc_pkg::DIVISOR_W-1:0] i_divisor,
    input  logic [$clog2(DW+1)-1:0]    i_steps,
    output logic                       o_busy,
    output logic [DW-1:0]              o_quotient
);
    localparam int NW  = srpc_pkg::DIVISOR_W;
    localparam int STW = $clog2(DW+1);

    logic            r_busy;
    logic [STW-1:0]  r_cnt;
    logic [NW-1:0]   r_rem;
    logic [NW-1:0]   r_div;
    logic [DW-1:0]   r_quo;
    logic [NW:0]     w_trial;
    logic [NW:0]     w_sub;
    logic            w_ge;

    // One quotient bit per cycle, restoring
    assign w_trial = {r_rem, r_quo[DW-1]};
    assign w_ge    = w_trial >= {1'b0, r_div};
    assign w_sub   = w_trial - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= (i_steps != '0);
            r_cnt  <= i_steps;
        end else if (r_busy) begin
            r_cnt <= r_cnt - STW'(1);
            if (r_cnt == STW'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    // Upper dividend bits preload the remainder; caller keeps them below divisor
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= NW'(i_dividend >> i_steps);
            r_quo <= i_dividend << (STW'(DW) - i_steps);
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_sub[NW-1:0] : w_trial[NW-1:0];
            r_quo <= {r_quo[DW-2:0], w_ge};
        end
    end

    assign o_busy     = r_busy;
    assign o_quotient = r_quo;

    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy) else $error("divider restarted while busy");
    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> (i_divisor != '0)) else $error("divider started with zero divisor");
    a_cnt_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_busy |-> (r_cnt == '0)) else $error("divider count left over");

endmodule

/* src/srpc_sqrt.sv */
module srpc_sqrt #(
    parameter int DW = 57
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic [DW-1:0]          i_value,
    output logic                   o_busy,
    output logic [(DW+1)/2-1:0]    o_root
);
    localparam int RW  = (DW + 1) / 2;
    localparam int CTW = $clog2(RW + 1);

    logic            r_busy;
    logic [CTW-1:0]  r_cnt;
    logic [2*RW-1:0] r_rad;
    logic [RW+1:0]   r_rem;
    logic [RW-1:0]   r_root;
    logic [RW+3:0]   w_a;
    logic [RW+3:0]   w_b;
    logic            w_ge;

    // Two radicand bits per cycle, one root bit
    assign w_a  = {r_rem, r_rad[2*RW-1 -: 2]};
    assign w_b  = {2'b00, r_root, 2'b01};
    assign w_ge = w_a >= w_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CTW'(RW);
        end else if (r_busy) begin
            r_cnt <= r_cnt - CTW'(1);
            if (r_cnt == CTW'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rad  <= (2*RW)'(i_value);
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_rem  <= w_ge ? (RW+2)'(w_a - w_b) : (RW+2)'(w_a);
            r_root <= {r_root[RW-2:0], w_ge};
            r_rad  <= r_rad << 2;
        end
    end

    assign o_busy = r_busy;
    assign o_root = r_root;

    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy) else $error("square root restarted while busy");
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_rem <= (RW+2)'({r_root, 1'b0}))) else $error("root remainder too large");
    a_busy_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_busy) |-> (r_cnt == CTW'(RW))) else $error("root step count wrong");

endmodule

/* src/spectral_ratio_pixel_classifier.sv */
// Load items (ratio entry, class entry, band sample) are taken while idle. A band-15
// item starts a pixel: a prep step, a skip of each table entry not in use, and per entry
// in use a ratio division (unless the ratio needs none) and a deviation division;
// per tested class with entries, mean and root mean square norms divide the summed
// deviations by the count (root mean square adds a root); then an output step. The
// shared serial divider (one quotient bit a cycle) and root unit do this work. One pixel
// is worked at a time; loads are taken while a result waits on the output. Reset
// (synchronous, active low) clears registers and band store, then sweeps the ratio table, taking no item meanwhile.
module spectral_ratio_pixel_classifier #(
    parameter int TABLE_ENTRIES = srpc_pkg::TABLE_ENTRIES_DEF,
    parameter int CLASSES       = srpc_pkg::CLASSES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [1:0]         i_action,
    input  logic [7:0]         i_slot_index,
    input  logic [3:0]         i_ratio_band_a,
    input  logic [3:0]         i_ratio_band_b,
    input  logic [6:0]         i_entry_class,
    input  logic [15:0]        i_ratio_mean,
    input  logic [15:0]        i_ratio_sigma,
    input  logic [15:0]        i_change_threshold,
    input  logic [15:0]        i_distance_threshold,
    input  logic [7:0]         i_class_priority,
    input  logic [3:0]         i_band_index,
    input  logic signed [15:0] i_band_value,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [6:0]         o_pixel_class,
    output logic [15:0]        o_change_magnitude,
    output logic               o_missing_threshold
);
    localparam int AW   = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CAW  = (CLASSES > 1) ? $clog2(CLASSES) : 1;
    localparam int CW   = $clog2(TABLE_ENTRIES + 1);
    localparam int SDW  = srpc_pkg::SD_W;
    localparam int SUMW = SDW + CW;
    localparam int SQW  = 2 * SDW + CW;
    localparam int DW   = SQW;
    localparam int STW  = $clog2(DW + 1);
    localparam int RTW  = (DW + 1) / 2;

    localparam logic [4:0] S_CLR   = 5'd0;
    localparam logic [4:0] S_IDLE  = 5'd1;
    localparam logic [4:0] S_PREP  = 5'd2;
    localparam logic [4:0] S_ERD   = 5'd3;
    localparam logic [4:0] S_EDAT  = 5'd4;
    localparam logic [4:0] S_XA    = 5'd5;
    localparam logic [4:0] S_XB    = 5'd6;
    localparam logic [4:0] S_RAT1  = 5'd7;
    localparam logic [4:0] S_RAT2  = 5'd8;
    localparam logic [4:0] S_RDIV  = 5'd9;
    localparam logic [4:0] S_SDST  = 5'd10;
    localparam logic [4:0] S_SDDIV = 5'd11;
    localparam logic [4:0] S_SQ    = 5'd12;
    localparam logic [4:0] S_ACC   = 5'd13;
    localparam logic [4:0] S_CRD   = 5'd14;
    localparam logic [4:0] S_CDAT  = 5'd15;
    localparam logic [4:0] S_CDIV  = 5'd16;
    localparam logic [4:0] S_SQRT  = 5'd17;
    localparam logic [4:0] S_CEVAL = 5'd18;
    localparam logic [4:0] S_FIN   = 5'd19;

    typedef struct packed {
        logic [CW-1:0]   cnt;
        logic [SUMW-1:0] sum;
        logic [SQW-1:0]  sumsq;
        logic [SDW-1:0]  mx;
    } t_acc;

    // Configuration registers
    logic              r_pan, r_swap, r_ronly;
    logic [15:0]       r_shthr, r_minsig;
    logic [1:0]        r_norm;
    logic [6:0]        r_ccount;

    // Memories
    srpc_pkg::t_ratio_entry ratio_mem [TABLE_ENTRIES];
    srpc_pkg::t_class_entry class_mem [CLASSES];
    t_acc                   acc_mem   [CLASSES];

    logic [4:0]                 r_state;
    logic [AW-1:0]              r_idx;
    logic [7:0]                 r_cls;
    logic signed [15:0]         r_band [16];
    logic signed [15:0]         r_x    [8];
    logic signed [15:0]         r_shade;
    logic                       r_bnd1;
    logic [15:0]                r_mag;
    logic [CLASSES-1:0]         r_acc_vld;
    srpc_pkg::t_ratio_entry     r_ent;
    srpc_pkg::t_class_entry     r_cent;
    t_acc                       r_acc_rd;
    logic signed [15:0]         r_xa, r_xb;
    logic signed [16:0]         r_s;
    logic signed [32:0]         r_n;
    logic [15:0]                r_ratio;
    logic [SDW-1:0]             r_sd;
    logic [2*SDW-1:0]           r_sq;
    logic [SDW-1:0]             r_dist;
    logic                       r_dif, r_bnd, r_cnt_ok;
    logic                       r_missing;
    logic [6:0]                 r_best;
    logic [7:0]                 r_best_pri;
    logic [SDW-1:0]             r_best_dist;
    logic                       r_out_vld;
    logic [6:0]                 r_out_cls;
    logic [15:0]                r_out_mag;
    logic                       r_out_miss;

    logic                       w_accept;
    logic [7:0]                 w_limit;
    logic signed [15:0]         w_b [16];
    logic signed [15:0]         w_xs [8];
    logic signed [15:0]         w_shade;
    logic                       w_bnd1;
    logic [15:0]                w_mag;
    logic [32:0]                w_abs_n;
    logic [16:0]                w_abs_s;
    logic [15:0]                w_diff;
    logic [15:0]                w_divs;
    t_acc                       w_acc;
    t_acc                       w_acc_new;
    logic                       w_rattest;
    logic                       w_pass;
    logic                       w_better;
    logic                       w_div_start;
    logic [DW-1:0]              w_div_dividend;
    logic [srpc_pkg::DIVISOR_W-1:0] w_div_divisor;
    logic [STW-1:0]             w_div_steps;
    logic                       w_div_busy;
    logic [DW-1:0]              w_div_quo;
    logic                       w_sqrt_start;
    logic                       w_sqrt_busy;
    logic [RTW-1:0]             w_sqrt_root;
    logic [CAW-1:0]             w_acc_raddr;
    logic                       w_acc_re;

    assign w_accept = i_in_valid && o_in_ready;
    assign w_limit  = (8'(r_ccount) > 8'(CLASSES)) ? 8'(CLASSES) : 8'(r_ccount);

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pan    <= 1'b0;
            r_swap   <= 1'b0;
            r_shthr  <= '0;
            r_norm   <= srpc_pkg::NORM_MAX;
            r_ronly  <= 1'b0;
            r_minsig <= 16'd256;
            r_ccount <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                srpc_pkg::CFG_PAN:    r_pan    <= i_cfg_data[0];
                srpc_pkg::CFG_SWAP:   r_swap   <= i_cfg_data[0];
                srpc_pkg::CFG_SHADOW: r_shthr  <= i_cfg_data;
                srpc_pkg::CFG_NORM:   r_norm   <= i_cfg_data[1:0];
                srpc_pkg::CFG_RONLY:  r_ronly  <= i_cfg_data[0];
                srpc_pkg::CFG_MINSIG: r_minsig <= i_cfg_data;
                srpc_pkg::CFG_COUNT:  r_ccount <= i_cfg_data[6:0];
                default: ;
            endcase
        end
    end

    // Band store
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 16; i++) r_band[i] <= '0;
        end else if (w_accept && i_action == srpc_pkg::ACT_BAND) begin
            r_band[i_band_index] <= i_band_value;
        end
    end

    // Pixel prep: epoch swap, change magnitude, ratio bands, shade
    always_comb begin
        logic signed [17:0] d;
        logic [7:0]         dc;
        logic [7:0]         ad;
        logic [10:0]        sum;
        logic signed [16:0] pd;
        sum = '0;
        for (int i = 0; i < 16; i++) begin
            w_b[i] = r_band[4'(i) ^ {r_swap, 3'b000}];
        end
        for (int i = 0; i < 8; i++) begin
            d = 18'(w_b[i+8]) - 18'(w_b[i]) + 18'sd128;
            if (d < 0) dc = 8'd0;
            else if (d > 18'sd255) dc = 8'd255;
            else dc = d[7:0];
            ad  = (dc >= 8'd128) ? dc - 8'd128 : 8'd128 - dc;
            sum = sum + 11'(ad);
        end
        pd = 17'(w_b[1]) - 17'(w_b[0]);
        if (r_pan) w_mag = (pd < 0) ? 16'(-pd) : 16'(pd);
        else       w_mag = 16'(sum[10:3]);
        for (int i = 0; i < 8; i++) begin
            w_xs[i] = r_pan ? w_b[2+i] : w_b[8+i];
        end
        w_shade = r_pan ? w_b[0] : w_b[2];
        w_bnd1  = (w_xs[0] > 0) && (w_xs[0] < 16'sd32767) &&
                  (w_xs[5] > 0) && (w_xs[5] < 16'sd32767);
    end

    // Ratio operands and per-entry distance terms
    assign w_abs_n = (r_n < 0) ? 33'(-r_n) : 33'(r_n);
    assign w_abs_s = (r_s < 0) ? 17'(-r_s) : 17'(r_s);
    assign w_diff  = (r_ratio > r_ent.mean) ? r_ratio - r_ent.mean : r_ent.mean - r_ratio;
    always_comb begin
        w_divs = (r_ent.sigma > r_minsig) ? r_ent.sigma : r_minsig;
        if (w_divs == '0) w_divs = 16'd1;
    end

    // Accumulator view: entries not touched this pixel read as zero
    always_comb begin
        logic [CAW-1:0] a;
        a = (r_state == S_CDAT || r_state == S_CEVAL || r_state == S_CDIV ||
             r_state == S_SQRT) ? CAW'(r_cls - 8'd1) : CAW'(r_ent.cls - 7'd1);
        w_acc = r_acc_vld[a] ? r_acc_rd : '0;
    end

    always_comb begin
        w_acc_new       = w_acc;
        w_acc_new.cnt   = w_acc.cnt + CW'(1);
        w_acc_new.sum   = w_acc.sum + SUMW'(r_sd);
        w_acc_new.sumsq = w_acc.sumsq + SQW'(r_sq);
        if (r_sd > w_acc.mx) w_acc_new.mx = r_sd;
    end

    // Class decision
    assign w_rattest = (32'(r_dist) * 32'd100) < (32'(r_cent.dist_thr) << 8);
    assign w_pass    = r_dif && (r_bnd || r_ronly) && r_cnt_ok && w_rattest;
    assign w_better  = (r_best == '0) || (r_cent.priority_lvl < r_best_pri) ||
                       ((r_cent.priority_lvl == r_best_pri) && (r_dist < r_best_dist));

    // Divider requests
    always_comb begin
        w_div_start    = 1'b0;
        w_div_dividend = '0;
        w_div_divisor  = '0;
        w_div_steps    = '0;
        priority case (r_state)
            S_RAT2: begin
                w_div_start    = (r_s != 0) && (r_n != 0) && ((r_n < 0) == (r_s < 0)) &&
                                 (w_abs_n < {w_abs_s, 16'h0000});
                w_div_dividend = DW'(w_abs_n);
                w_div_divisor  = w_abs_s;
                w_div_steps    = STW'(srpc_pkg::RATIO_W);
            end
            S_SDST: begin
                w_div_start    = 1'b1;
                w_div_dividend = DW'({w_diff, 8'h00});
                w_div_divisor  = 17'(w_divs);
                w_div_steps    = STW'(SDW);
            end
            S_CDAT: begin
                w_div_start    = (w_acc.cnt != '0) &&
                                 (r_norm == srpc_pkg::NORM_MEAN || r_norm == srpc_pkg::NORM_RMS);
                w_div_dividend = (r_norm == srpc_pkg::NORM_MEAN) ? DW'(w_acc.sum)
                                                                  : DW'(w_acc.sumsq);
                w_div_divisor  = 17'(w_acc.cnt);
                w_div_steps    = (r_norm == srpc_pkg::NORM_MEAN) ? STW'(SUMW) : STW'(SQW);
            end
            default: ;
        endcase
    end

    assign w_sqrt_start = (r_state == S_CDIV) && !w_div_busy && (r_norm == srpc_pkg::NORM_RMS);

    srpc_div #(.DW(DW)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_div_dividend),
        .i_divisor  (w_div_divisor),
        .i_steps    (w_div_steps),
        .o_busy     (w_div_busy),
        .o_quotient (w_div_quo)
    );

    srpc_sqrt #(.DW(DW)) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_sqrt_start),
        .i_value (w_div_quo),
        .o_busy  (w_sqrt_busy),
        .o_root  (w_sqrt_root)
    );

    // Ratio table: one write port (clear sweep or load), one registered read
    always_ff @(posedge i_clk) begin
        if (r_state == S_CLR) begin
            ratio_mem[r_idx] <= '0;
        end else if (w_accept && i_action == srpc_pkg::ACT_RATIO &&
                     13'(i_slot_index) < 13'(TABLE_ENTRIES)) begin
            ratio_mem[AW'(i_slot_index)] <= '{band_a: i_ratio_band_a, band_b: i_ratio_band_b,
                                              cls: i_entry_class, mean: i_ratio_mean,
                                              sigma: i_ratio_sigma};
        end
        if (r_state == S_ERD) begin
            r_ent <= ratio_mem[r_idx];
        end
    end

    // Class table
    always_ff @(posedge i_clk) begin
        if (w_accept && i_action == srpc_pkg::ACT_CLASS && {1'b0, i_slot_index} < 9'(CLASSES)) begin
            class_mem[CAW'(i_slot_index)] <= '{change_thr: i_change_threshold,
                                               dist_thr: i_distance_threshold,
                                               priority_lvl: i_class_priority};
        end
        if (r_state == S_CRD) begin
            r_cent <= class_mem[CAW'(r_cls - 8'd1)];
        end
    end

    // Per-class accumulators: read, update, write back; accesses never overlap
    assign w_acc_re    = (r_state == S_SDST) || (r_state == S_CRD);
    assign w_acc_raddr = (r_state == S_CRD) ? CAW'(r_cls - 8'd1) : CAW'(r_ent.cls - 7'd1);
    always_ff @(posedge i_clk) begin
        if (r_state == S_ACC) begin
            acc_mem[CAW'(r_ent.cls - 7'd1)] <= w_acc_new;
        end
        if (w_acc_re) begin
            r_acc_rd <= acc_mem[w_acc_raddr];
        end
    end

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLR;
            r_idx     <= '0;
            r_cls     <= '0;
            r_acc_vld <= '0;
            r_out_vld <= 1'b0;
        end else begin
            // the finish state reloads the output register itself
            if (r_out_vld && i_out_ready && r_state != S_FIN) r_out_vld <= 1'b0;
            unique case (r_state)
                S_CLR: begin
                    if (r_idx == AW'(TABLE_ENTRIES - 1)) begin
                        r_idx   <= '0;
                        r_state <= S_IDLE;
                    end else begin
                        r_idx <= r_idx + AW'(1);
                    end
                end
                S_IDLE: begin
                    if (w_accept && i_action == srpc_pkg::ACT_BAND &&
                        i_band_index == srpc_pkg::LAST_BAND) begin
                        r_state <= S_PREP;
                    end
                end
                S_PREP: begin
                    for (int i = 0; i < 8; i++) r_x[i] <= w_xs[i];
                    r_shade     <= w_shade;
                    r_bnd1      <= w_bnd1;
                    r_mag       <= w_mag;
                    r_acc_vld   <= '0;
                    r_missing   <= 1'b0;
                    r_best      <= '0;
                    r_best_pri  <= '0;
                    r_best_dist <= '0;
                    r_idx       <= '0;
                    r_state     <= S_ERD;
                end
                S_ERD: r_state <= S_EDAT;
                S_EDAT: begin
                    if (r_ent.cls == '0 || 8'(r_ent.cls) > w_limit) begin
                        if (r_idx == AW'(TABLE_ENTRIES - 1)) begin
                            r_cls   <= 8'd1;
                            r_state <= (w_limit == '0) ? S_FIN : S_CRD;
                        end else begin
                            r_idx   <= r_idx + AW'(1);
                            r_state <= S_ERD;
                        end
                    end else begin
                        r_state <= S_XA;
                    end
                end
                S_XA: begin
                    r_xa    <= r_x[r_ent.band_a[2:0] + 3'd7];
                    r_state <= S_XB;
                end
                S_XB: begin
                    r_xb    <= r_x[r_ent.band_b[2:0] + 3'd7];
                    r_state <= S_RAT1;
                end
                S_RAT1: begin
                    r_s     <= 17'(r_xa) + 17'(r_xb);
                    r_n     <= 33'(r_xa) * 33'sd51200;
                    r_state <= S_RAT2;
                end
                S_RAT2: begin
                    priority if (r_s == 0) begin
                        r_ratio <= (r_n > 0) ? 16'hFFFF : ((r_n < 0) ? 16'd0 : 16'd25600);
                        r_state <= S_SDST;
                    end else if (r_n == 0 || ((r_n < 0) != (r_s < 0))) begin
                        r_ratio <= '0;
                        r_state <= S_SDST;
                    end else if (w_abs_n >= {w_abs_s, 16'h0000}) begin
                        r_ratio <= 16'hFFFF;
                        r_state <= S_SDST;
                    end else begin
                        r_state <= S_RDIV;
                    end
                end
                S_RDIV: begin
                    if (!w_div_busy) begin
                        r_ratio <= w_div_quo[15:0];
                        r_state <= S_SDST;
                    end
                end
                S_SDST: r_state <= S_SDDIV;
                S_SDDIV: begin
                    if (!w_div_busy) begin
                        r_sd    <= w_div_quo[SDW-1:0];
                        r_state <= S_SQ;
                    end
                end
                S_SQ: begin
                    r_sq    <= r_sd * r_sd;
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    r_acc_vld[CAW'(r_ent.cls - 7'd1)] <= 1'b1;
                    if (r_idx == AW'(TABLE_ENTRIES - 1)) begin
                        r_cls   <= 8'd1;
                        r_state <= (w_limit == '0) ? S_FIN : S_CRD;
                    end else begin
                        r_idx   <= r_idx + AW'(1);
                        r_state <= S_ERD;
                    end
                end
                S_CRD: r_state <= S_CDAT;
                S_CDAT: begin
                    if (r_cent.change_thr == '0) r_missing <= 1'b1;
                    r_dif <= (r_mag > r_cent.change_thr) && (r_shade > $signed(r_shthr));
                    r_bnd <= (r_cls == 8'd1) ? r_bnd1 : 1'b1;
                    if (r_norm == srpc_pkg::NORM_MEAN || r_norm == srpc_pkg::NORM_RMS) begin
                        r_cnt_ok <= (w_acc.cnt != '0);
                        r_dist   <= '0;
                        r_state  <= (w_acc.cnt != '0) ? S_CDIV : S_CEVAL;
                    end else begin
                        r_cnt_ok <= 1'b1;
                        r_dist   <= w_acc.mx;
                        r_state  <= S_CEVAL;
                    end
                end
                S_CDIV: begin
                    if (!w_div_busy) begin
                        if (r_norm == srpc_pkg::NORM_MEAN) begin
                            r_dist  <= w_div_quo[SDW-1:0];
                            r_state <= S_CEVAL;
                        end else begin
                            r_state <= S_SQRT;
                        end
                    end
                end
                S_SQRT: begin
                    if (!w_sqrt_busy) begin
                        r_dist  <= w_sqrt_root[SDW-1:0];
                        r_state <= S_CEVAL;
                    end
                end
                S_CEVAL: begin
                    if (w_pass && w_better) begin
                        r_best      <= r_cls[6:0];
                        r_best_pri  <= r_cent.priority_lvl;
                        r_best_dist <= r_dist;
                    end
                    if (r_cls == w_limit) begin
                        r_state <= S_FIN;
                    end else begin
                        r_cls   <= r_cls + 8'd1;
                        r_state <= S_CRD;
                    end
                end
                S_FIN: begin
                    if (!r_out_vld || i_out_ready) begin
                        r_out_vld  <= 1'b1;
                        r_out_cls  <= r_missing ? 7'd0 : r_best;
                        r_out_mag  <= r_mag;
                        r_out_miss <= r_missing;
                        r_state    <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_ready          = (r_state == S_IDLE);
    assign o_out_valid         = r_out_vld;
    assign o_pixel_class       = r_out_cls;
    assign o_change_magnitude  = r_out_mag;
    assign o_missing_threshold = r_out_miss;

    a_pixel_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_action == srpc_pkg::ACT_BAND && i_band_index == srpc_pkg::LAST_BAND)
        |=> (r_state == S_PREP)) else $error("pixel did not start");
    a_missing_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_missing_threshold) |-> (o_pixel_class == '0))
        else $error("class reported with missing threshold");
    a_class_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (8'(o_pixel_class) <= 8'(CLASSES))) else $error("class out of range");
    a_no_take_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN && r_out_vld && !i_out_ready) |=> (r_state == S_FIN))
        else $error("result dropped while output stalled");
    a_best_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CEVAL) |-> (8'(r_best) < r_cls)) else $error("best class ahead of walk");

endmodule
